[src/sgt_pkg.sv]
`default_nettype none

package sgt_pkg;

  localparam int VERT_N     = 16;
  localparam int VID_W      = 4;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 1'b1;

  localparam logic [CNT_W-1:0] ACTIVE_RESET = 5'd16;
  localparam logic [VID_W-1:0] START_RESET  = 4'd1;

  typedef struct packed {
    logic [VID_W-1:0]  row_index;
    logic [VERT_N-1:0] row_bits;
    logic              last_row;
  } item_t;

  typedef struct packed {
    logic [VID_W-1:0] vertex;
    logic             last_vertex;
  } result_t;

  typedef struct packed {
    logic             found;
    logic [VID_W-1:0] idx;
  } pick_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN
  } state_t;

endpackage

`default_nettype wire

[src/sgt_lane.sv]
`default_nettype none

// One neighbour slot: flag an edge to an unvisited vertex inside the active range.
module sgt_lane #(
  parameter int LANE = 0
) (
  input  wire logic                      edge_bit,
  input  wire logic                      seen_bit,
  input  wire logic [sgt_pkg::CNT_W-1:0] count,
  output logic                           hit
);

  localparam logic [sgt_pkg::CNT_W-1:0] LaneId = sgt_pkg::CNT_W'(LANE);

  assign hit = edge_bit & ~seen_bit & (LaneId < count);

endmodule

`default_nettype wire

[src/sgt_merge.sv]
`default_nettype none

// Combine the lane flags: take the lowest flagged vertex.
module sgt_merge (
  input  wire logic [sgt_pkg::VERT_N-1:0] hits,
  output sgt_pkg::pick_t                  pick
);

  always_comb begin
    pick.found = |hits;
    pick.idx   = '0;
    for (int i = sgt_pkg::VERT_N - 1; i >= 0; i--) begin
      if (hits[i]) begin
        pick.idx = sgt_pkg::VID_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

[src/stack_graph_traversal.sv]
`default_nettype none

// The last row starts a run; busy then holds through a POP state reading the row of each
// popped vertex, a SCAN step per discovery, one closing each scan and a final POP finding
// the stack empty. The first result comes from the first discovery, from the final POP if
// the start vertex has no neighbour in range, or from the last row if it is out of range.
// Throughput: one row per cycle when idle; results leave one per cycle at most, the receiver
// cannot stall. Reset (rst, synchronous) restores 16 vertices, start vertex 1 and idle.
module stack_graph_traversal #(
  parameter int MAX_VERTICES = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire sgt_pkg::item_t                      item,
  output logic                                     result_valid,
  output sgt_pkg::result_t                         result,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sgt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [sgt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Vertex count cap: the smaller of the parameter and the row width.
  localparam int CapInt = (MAX_VERTICES < sgt_pkg::VERT_N) ? MAX_VERTICES : sgt_pkg::VERT_N;
  localparam logic [sgt_pkg::CNT_W-1:0] Cap = sgt_pkg::CNT_W'(CapInt);

  sgt_pkg::state_t state, state_next;

  logic [sgt_pkg::CNT_W-1:0]  active_vertices;
  logic [sgt_pkg::VID_W-1:0]  start_vertex;
  logic [sgt_pkg::VERT_N-1:0] visited;
  logic [sgt_pkg::CNT_W-1:0]  depth;
  logic [sgt_pkg::VID_W-1:0]  pend_vertex;

  // Adjacency rows and the vertex stack.
  logic [sgt_pkg::VERT_N-1:0] adj_mem [sgt_pkg::VERT_N];
  logic [sgt_pkg::VERT_N-1:0] adj_row;
  logic [sgt_pkg::VID_W-1:0]  stack_mem [sgt_pkg::VERT_N];

  logic                       accept;
  logic                       load_run;
  logic                       start_ok;
  logic [sgt_pkg::CNT_W-1:0]  n_eff;
  logic [sgt_pkg::VID_W-1:0]  top_idx;
  logic [sgt_pkg::VID_W-1:0]  pop_vertex;
  logic [sgt_pkg::VERT_N-1:0] hits;
  sgt_pkg::pick_t             pick;

  logic do_pop;
  logic do_find;
  logic do_finish;

  assign busy      = (state != sgt_pkg::ST_IDLE);
  // Hold register writes off while a run is in flight.
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;
  assign load_run  = accept & item.last_row;

  // Clamp the vertex count; a start vertex outside it yields a lone result.
  assign n_eff    = (active_vertices > Cap) ? Cap : active_vertices;
  assign start_ok = {1'b0, start_vertex} < n_eff;

  // Top of stack sits one below the depth.
  assign top_idx    = sgt_pkg::VID_W'(depth - sgt_pkg::CNT_W'(1));
  assign pop_vertex = stack_mem[top_idx];

  // One lane per candidate neighbour, all examined in the same cycle.
  for (genvar j = 0; j < sgt_pkg::VERT_N; j++) begin : g_lane
    sgt_lane #(
      .LANE (j)
    ) u_lane (
      .edge_bit (adj_row[j]),
      .seen_bit (visited[j]),
      .count    (n_eff),
      .hit      (hits[j])
    );
  end

  sgt_merge u_merge (
    .hits (hits),
    .pick (pick)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sgt_pkg::ST_IDLE: begin
        if (load_run && start_ok) begin
          state_next = sgt_pkg::ST_POP;
        end
      end
      sgt_pkg::ST_POP: begin
        if (depth == '0) begin
          state_next = sgt_pkg::ST_IDLE;
        end else begin
          state_next = sgt_pkg::ST_SCAN;
        end
      end
      sgt_pkg::ST_SCAN: begin
        if (!pick.found) begin
          state_next = sgt_pkg::ST_POP;
        end
      end
      default: state_next = sgt_pkg::ST_IDLE;
    endcase
  end

  // Controller actions.
  always_comb begin
    do_pop    = 1'b0;
    do_find   = 1'b0;
    do_finish = 1'b0;
    unique case (state)
      sgt_pkg::ST_IDLE: ;
      sgt_pkg::ST_POP: begin
        do_pop    = (depth != '0);
        do_finish = (depth == '0);
      end
      sgt_pkg::ST_SCAN: begin
        do_find = pick.found;
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= sgt_pkg::ST_IDLE;
      active_vertices <= sgt_pkg::ACTIVE_RESET;
      start_vertex    <= sgt_pkg::START_RESET;
      visited         <= '0;
      depth           <= '0;
      result_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      // Strobe a result on a lone start vertex, on each discovery and at the close.
      result_valid <= (load_run && !start_ok) || do_find || do_finish;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sgt_pkg::REG_ACTIVE: active_vertices <= cfg_data;
          sgt_pkg::REG_START:  start_vertex    <= cfg_data[sgt_pkg::VID_W-1:0];
          default: ;
        endcase
      end

      // Clear the map at the start of each run; seed it with the start vertex.
      if (load_run) begin
        if (start_ok) begin
          visited <= sgt_pkg::VERT_N'(1) << start_vertex;
          depth   <= sgt_pkg::CNT_W'(1);
        end else begin
          visited <= '0;
          depth   <= '0;
        end
      end

      if (do_pop) begin
        depth <= depth - sgt_pkg::CNT_W'(1);
      end

      // Each discovery releases the vertex held back before it.
      if (do_find) begin
        visited <= visited | (sgt_pkg::VERT_N'(1) << pick.idx);
        depth   <= depth + sgt_pkg::CNT_W'(1);
      end
    end
  end

  // Payload: rows, stack, held-back vertex and the result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      adj_mem[item.row_index] <= item.row_bits;
    end

    if (do_pop) begin
      adj_row <= adj_mem[pop_vertex];
    end

    if (load_run) begin
      stack_mem[0] <= start_vertex;
      pend_vertex  <= start_vertex;
      // Out-of-range start: the start vertex alone closes the run.
      result.vertex      <= start_vertex;
      result.last_vertex <= 1'b1;
    end

    if (do_find) begin
      stack_mem[depth[sgt_pkg::VID_W-1:0]] <= pick.idx;
      pend_vertex        <= pick.idx;
      result.vertex      <= pend_vertex;
      result.last_vertex <= 1'b0;
    end

    // Stack empty: the held-back vertex is the final one.
    if (do_finish) begin
      result.vertex      <= pend_vertex;
      result.last_vertex <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[sim/tb_stack_graph_traversal.sv]
`default_nettype none

module tb_stack_graph_traversal;

  // Settle time before a register write.
  localparam int SETTLE_CYCLES = 64;
  // Cycles without any transfer or result before the run is declared hung.
  localparam int QUIET_LIMIT   = 4000;
  localparam int REPORT_MAX    = 10;
  localparam int ITEM_TARGET   = 350;
  // From this many queued rows on, the sender stops idling.
  localparam int CALM_FROM     = 300;

  logic                           clk          = 1'b0;
  logic                           rst          = 1'b1;
  logic                           start        = 1'b0;
  logic                           busy;
  sgt_pkg::item_t                 item         = '0;
  logic                           result_valid;
  sgt_pkg::result_t               result;
  logic                           cfg_valid    = 1'b0;
  logic                           cfg_ready;
  logic [sgt_pkg::CFG_IDX_W-1:0]  cfg_index    = sgt_pkg::REG_ACTIVE;
  logic [sgt_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

  // Rows waiting to be offered, and the vertex order still owed by the block.
  sgt_pkg::item_t   row_queue[$];
  sgt_pkg::result_t expected_order[$];

  // Predictor copy of the adjacency rows and of both registers.
  logic [sgt_pkg::VERT_N-1:0] adj_rows [sgt_pkg::VERT_N];
  logic [sgt_pkg::CNT_W-1:0]  vert_limit  = sgt_pkg::ACTIVE_RESET;
  logic [sgt_pkg::VID_W-1:0]  root_vertex = sgt_pkg::START_RESET;

  int  cfg_xfers   = 0;
  int  errors      = 0;
  int  quiet       = 0;
  int  gap_left    = 0;
  int  gap_odds    = 0;
  bit  took_item   = 1'b0;

  stack_graph_traversal u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Store the row, and on the final row walk the graph depth first from the root,
  // queueing every discovered vertex in the order the block must emit it.
  task automatic predict_discovery(input sgt_pkg::item_t it);
    logic [sgt_pkg::VERT_N-1:0] seen;
    logic [sgt_pkg::VID_W-1:0]  stk [sgt_pkg::VERT_N];
    logic [sgt_pkg::VID_W-1:0]  order [$];
    logic [sgt_pkg::VID_W-1:0]  node;
    logic [sgt_pkg::VERT_N-1:0] row;
    sgt_pkg::result_t           r;
    int                         depth;
    int                         lim;
    int                         j;
    adj_rows[it.row_index] = it.row_bits;
    if (!it.last_row) return;
    // Clamp the vertex count to the matrix size; 0 and 1 pass through unchanged.
    lim   = (vert_limit > sgt_pkg::VERT_N) ? sgt_pkg::VERT_N : int'(vert_limit);
    seen  = '0;
    depth = 0;
    order.push_back(root_vertex);
    // A root outside the active range is emitted alone.
    if (int'(root_vertex) < lim) begin
      seen[root_vertex] = 1'b1;
      stk[0] = root_vertex;
      depth  = 1;
      while (depth > 0) begin
        depth--;
        node = stk[depth];
        row  = adj_rows[node];
        // Bits at or above the active count are never looked at.
        for (j = 0; j < lim; j++) begin
          if (row[j] && !seen[j]) begin
            seen[j] = 1'b1;
            order.push_back(sgt_pkg::VID_W'(j));
            stk[depth] = sgt_pkg::VID_W'(j);
            depth++;
          end
        end
      end
    end
    foreach (order[k]) begin
      r.vertex      = order[k];
      r.last_vertex = (k == order.size() - 1);
      expected_order.push_back(r);
    end
  endtask

  // Monitor: check results first, then record item and register transfers, then the watchdog.
  always @(posedge clk) begin
    took_item = 1'b0;
    if (!rst) begin
      if (result_valid) begin
        if (expected_order.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("unexpected result: vertex %0d last %0b", result.vertex, result.last_vertex);
        end else begin
          if (result.vertex !== expected_order[0].vertex ||
              result.last_vertex !== expected_order[0].last_vertex) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("result mismatch: expected vertex %0d last %0b, got vertex %0d last %0b",
                       expected_order[0].vertex, expected_order[0].last_vertex,
                       result.vertex, result.last_vertex);
          end
          void'(expected_order.pop_front());
        end
      end
      if (start && !busy) begin
        took_item = 1'b1;
        predict_discovery(item);
        void'(row_queue.pop_front());
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sgt_pkg::REG_ACTIVE) vert_limit = cfg_data;
        else root_vertex = cfg_data[sgt_pkg::VID_W-1:0];
        cfg_xfers++;
      end
      if (took_item || result_valid || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("[stack_graph_traversal] ERROR");
        $finish;
      end
    end
  end

  // Driver: hold an offered row until its transfer, otherwise idle in bursts or offer the next.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else if (start && !took_item) begin
      // hold: the block is busy
    end else if (gap_left != 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (row_queue.size() != 0 && gap_odds != 0 &&
                 $urandom_range(gap_odds - 1) == 0) begin
      gap_left = $urandom_range(11);
      start <= 1'b0;
    end else if (row_queue.size() != 0) begin
      start <= 1'b1;
      item  <= row_queue[0];
    end else begin
      start <= 1'b0;
    end
  end

  task automatic queue_row(input int idx, input logic [sgt_pkg::VERT_N-1:0] bits,
                           input bit fin);
    sgt_pkg::item_t it;
    it.row_index = sgt_pkg::VID_W'(idx);
    it.row_bits  = bits;
    it.last_row  = fin;
    row_queue.push_back(it);
  endtask

  // Drain: wait until every row is taken and every vertex seen, then let the block go idle.
  task automatic settle();
    while (row_queue.size() != 0 || expected_order.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sgt_pkg::CFG_IDX_W-1:0] idx, input int value);
    int seen0;
    seen0 = cfg_xfers;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= sgt_pkg::CFG_DATA_W'(value);
    while (cfg_xfers == seen0) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [sgt_pkg::VERT_N-1:0] rand_row();
    case ($urandom_range(4))
      0:       return sgt_pkg::VERT_N'($urandom);
      1:       return sgt_pkg::VERT_N'($urandom & $urandom & $urandom);
      2:       return sgt_pkg::VERT_N'(1) << $urandom_range(sgt_pkg::VERT_N - 1);
      3:       return sgt_pkg::VERT_N'($urandom | $urandom);
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  initial begin : stimulus
    int issued;
    int cur_active;
    int lim;
    int nrows;
    int i;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Load every row first so that no traversal ever reads an unwritten row.
    // Row 0 reaches everything, rows 1..14 form a chain with self loops, row 15 is empty.
    for (i = 0; i < sgt_pkg::VERT_N; i++) begin
      if (i == 0) queue_row(i, '1, 1'b0);
      else if (i == sgt_pkg::VERT_N - 1) queue_row(i, '0, 1'b1);
      else queue_row(i, (sgt_pkg::VERT_N'(1) << (i + 1)) | (sgt_pkg::VERT_N'(1) << i), 1'b0);
    end
    settle();

    // Zero vertices: the root is out of range and stands alone.
    write_reg(sgt_pkg::REG_ACTIVE, 0);
    write_reg(sgt_pkg::REG_START, 0);
    queue_row(3, rand_row(), 1'b1);
    settle();

    // One vertex: only the root, whatever its row says.
    write_reg(sgt_pkg::REG_ACTIVE, 1);
    queue_row(0, '1, 1'b1);
    settle();

    // Count above the matrix size clamps to 16; root at the top vertex.
    write_reg(sgt_pkg::REG_ACTIVE, 31);
    write_reg(sgt_pkg::REG_START, sgt_pkg::VERT_N - 1);
    queue_row(sgt_pkg::VERT_N - 1, '1, 1'b1);
    settle();

    // Root beyond a two-vertex graph.
    write_reg(sgt_pkg::REG_ACTIVE, 2);
    queue_row(1, '1, 1'b1);
    settle();

    // Full graph from vertex 0 with an empty row in the middle.
    write_reg(sgt_pkg::REG_ACTIVE, 16);
    write_reg(sgt_pkg::REG_START, 0);
    queue_row(7, '0, 1'b1);
    settle();

    issued     = sgt_pkg::VERT_N + 5;
    cur_active = 16;

    // Random phases: new settings, a few rows, then a final row that sets off a run.
    while (issued < ITEM_TARGET) begin
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0:       cur_active = $urandom_range(1);
          1:       cur_active = $urandom_range(31, 17);
          default: cur_active = $urandom_range(16, 2);
        endcase
        write_reg(sgt_pkg::REG_ACTIVE, cur_active);
      end
      if ($urandom_range(3) != 0) begin
        lim = (cur_active > sgt_pkg::VERT_N) ? sgt_pkg::VERT_N : cur_active;
        if (lim == 0 || $urandom_range(4) == 0)
          write_reg(sgt_pkg::REG_START, $urandom_range(sgt_pkg::VERT_N - 1));
        else write_reg(sgt_pkg::REG_START, $urandom_range(lim - 1));
      end
      if (issued >= CALM_FROM) gap_odds = 0;
      else case ($urandom_range(2))
        0:       gap_odds = 0;
        1:       gap_odds = 3;
        default: gap_odds = 6;
      endcase
      nrows = $urandom_range(10);
      for (i = 0; i < nrows; i++)
        queue_row($urandom_range(sgt_pkg::VERT_N - 1), rand_row(), 1'b0);
      queue_row($urandom_range(sgt_pkg::VERT_N - 1), rand_row(), 1'b1);
      issued += nrows + 1;
      settle();
    end

    // settle() has already drained the block and waited out its latency.
    if (errors == 0) $display("[stack_graph_traversal] OK");
    else $display("[stack_graph_traversal] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
src/sgt_pkg.sv
src/sgt_lane.sv
src/sgt_merge.sv
src/stack_graph_traversal.sv
sim/tb_stack_graph_traversal.sv
